FILE: src/hcs_pkg.sv
package hcs_pkg;

   // histogram geometry
   localparam int BINS       = 256;
   localparam int BIN_BITS   = $clog2(BINS);
   localparam int BOUND_BITS = BIN_BITS + 1;
   localparam int PIXEL_BITS = 8;
   localparam int MODE_BITS  = 2;
   localparam int COUNT_BITS = 24;
   localparam int MIN_BITS   = 24;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = {PIXEL_BITS{1'b1}};

   // item modes
   localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_COUNT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MAP   = 2'd2;

   // divider: quotient is one pixel wide, one bit per step
   localparam int DIV_STEPS     = PIXEL_BITS;
   localparam int DIV_STEP_BITS = $clog2(DIV_STEPS);
   localparam int NUM_BITS      = 2 * PIXEL_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SCAN,
      ST_SETUP,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [NUM_BITS-1:0]   numerator;
      logic [PIXEL_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [PIXEL_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: src/hcs_div.sv
module hcs_div
   import hcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // restoring divider; numerator high half is known to be below the divisor
   logic                     run_ff;
   logic [DIV_STEP_BITS-1:0] step_ff;
   logic [PIXEL_BITS-1:0]    rem_ff;
   logic [PIXEL_BITS-1:0]    rem_in;
   logic [PIXEL_BITS-1:0]    quo_ff;
   logic [PIXEL_BITS-1:0]    quo_in;
   logic [PIXEL_BITS-1:0]    div_ff;
   logic [PIXEL_BITS:0]      trial;
   logic [PIXEL_BITS:0]      diff;
   logic                     fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[PIXEL_BITS-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
      quo_in = {quo_ff[PIXEL_BITS-2:0], fits};
   end

   assign rsp.done     = run_ff && (step_ff == DIV_STEP_BITS'(DIV_STEPS - 1));
   assign rsp.quotient = quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else if (req.start) begin
         run_ff  <= 1'b1;
         step_ff <= '0;
      end else if (run_ff) begin
         step_ff <= step_ff + 1'b1;
         if (rsp.done) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.numerator[NUM_BITS-1:PIXEL_BITS];
         quo_ff <= req.numerator[PIXEL_BITS-1:0];
         div_ff <= req.divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

FILE: src/histogram_contrast_stretch.sv
// clear and unused-mode items: busy stays low, no result
// count item: bin read, then write back, busy for one cycle
// map item, bounds known: the bound check gives the result at the ends, else the divider does
// first map item after a clear or count: a scan of all bins comes first, one bin per memory read
// the result strobe lasts one cycle and cannot be stalled
// synchronous active-high reset empties the histogram through per-bin valid bits
module histogram_contrast_stretch
   import hcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [MODE_BITS-1:0]  req_mode,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   output logic                  rsp_valid,
   output logic [PIXEL_BITS-1:0] rsp_out_pixel,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [MIN_BITS-1:0]   csr_min_count
);

   // control state
   state_type state_ff;
   state_type state_in;

   // histogram store and its valid bits (an invalid bin reads as zero)
   logic [COUNT_BITS-1:0] bin_mem [BINS];
   logic [BINS-1:0]       bin_valid_ff;
   logic [BINS-1:0]       bin_valid_in;
   logic [BIN_BITS-1:0]   mem_raddr;
   logic [COUNT_BITS-1:0] mem_rdata_ff;
   logic                  rd_valid_ff;
   logic                  mem_we;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic [COUNT_BITS-1:0] bin_value;

   // item and bound registers
   logic [PIXEL_BITS-1:0] pix_ff;
   logic [PIXEL_BITS-1:0] pix_in;
   logic [MIN_BITS-1:0]   min_count_ff;
   logic [BOUND_BITS-1:0] low_bin_ff;
   logic [BOUND_BITS-1:0] low_bin_in;
   logic [BOUND_BITS-1:0] high_bin_ff;
   logic [BOUND_BITS-1:0] high_bin_in;
   logic                  bounds_ready_ff;
   logic                  bounds_ready_in;

   // scan pipeline: issue counter, then compare in the cycle after the read is issued
   logic [BOUND_BITS-1:0] scan_idx_ff;
   logic [BOUND_BITS-1:0] scan_idx_in;
   logic                  cmp_vld_ff;
   logic                  cmp_vld_in;
   logic [BIN_BITS-1:0]   cmp_idx_ff;
   logic [BIN_BITS-1:0]   cmp_idx_in;
   logic                  over_min;

   // mapping
   logic [BOUND_BITS-1:0] pix_ext;
   logic                  below;
   logic                  above;
   logic                  flat;
   logic                  trivial;
   logic [PIXEL_BITS-1:0] span;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_in;

   logic                  accept;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign csr_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;

   // bin content as seen through the valid bit
   assign bin_value = rd_valid_ff ? mem_rdata_ff : '0;
   assign over_min  = (32'(bin_value) > 32'(min_count_ff));

   // bound tests on the held pixel
   always_comb begin
      pix_ext = {1'b0, pix_ff};
      below   = (pix_ext < low_bin_ff);
      above   = (pix_ext > high_bin_ff);
      flat    = (high_bin_ff <= low_bin_ff);
      trivial = below || above || flat;
      span    = pix_ff - low_bin_ff[BIN_BITS-1:0];
   end

   hcs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_COUNT: state_in = ST_COUNT;
                  MODE_MAP:   state_in = bounds_ready_ff ? ST_SETUP : ST_SCAN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_COUNT: state_in = ST_IDLE;
         ST_SCAN: begin
            // last bin is compared in the cycle the issue counter wraps
            if (scan_idx_ff[BIN_BITS]) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP:  state_in = trivial ? ST_IDLE : ST_DIVIDE;
         ST_DIVIDE: state_in = div_rsp.done ? ST_IDLE : ST_DIVIDE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      pix_in          = pix_ff;
      mem_raddr       = req_pixel;
      mem_we          = 1'b0;
      mem_wdata       = bin_value + 1'b1;
      bin_valid_in    = bin_valid_ff;
      bounds_ready_in = bounds_ready_ff;
      low_bin_in      = low_bin_ff;
      high_bin_in     = high_bin_ff;
      scan_idx_in     = scan_idx_ff;
      cmp_vld_in      = 1'b0;
      cmp_idx_in      = scan_idx_ff[BIN_BITS-1:0];
      rsp_valid_in    = 1'b0;
      rsp_pixel_in    = rsp_pixel_ff;
      div_req.start     = 1'b0;
      div_req.numerator = {span, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, span};
      div_req.divisor   = high_bin_ff[BIN_BITS-1:0] - low_bin_ff[BIN_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pix_in = req_pixel;
               unique case (req_mode)
                  MODE_CLEAR: begin
                     bin_valid_in    = '0;
                     bounds_ready_in = 1'b0;
                  end
                  MODE_COUNT: begin
                     bounds_ready_in = 1'b0;
                  end
                  MODE_MAP: begin
                     // prime the scan: no bin found yet
                     scan_idx_in = '0;
                     low_bin_in  = BOUND_BITS'(BINS);
                     high_bin_in = '0;
                     if (bounds_ready_ff) begin
                        low_bin_in  = low_bin_ff;
                        high_bin_in = high_bin_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COUNT: begin
            // saturating increment, write back
            mem_we = (bin_value != COUNT_MAX);
            if (mem_we) begin
               bin_valid_in[pix_ff] = 1'b1;
            end
         end
         ST_SCAN: begin
            mem_raddr = scan_idx_ff[BIN_BITS-1:0];
            if (!scan_idx_ff[BIN_BITS]) begin
               cmp_vld_in  = 1'b1;
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (cmp_vld_ff && over_min) begin
               if (low_bin_ff[BIN_BITS]) begin
                  low_bin_in = {1'b0, cmp_idx_ff};
               end
               high_bin_in = {1'b0, cmp_idx_ff};
            end
            if (scan_idx_ff[BIN_BITS]) begin
               bounds_ready_in = 1'b1;
            end
         end
         ST_SETUP: begin
            if (trivial) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = below ? '0 : PIXEL_MAX;
            end else begin
               div_req.start = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = div_rsp.quotient;
            end
         end
         default: begin
         end
      endcase
   end

   // histogram memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[pix_ff] <= mem_wdata;
      end
      mem_rdata_ff <= bin_mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         bin_valid_ff    <= '0;
         rd_valid_ff     <= 1'b0;
         bounds_ready_ff <= 1'b0;
         low_bin_ff      <= '0;
         high_bin_ff     <= '0;
         min_count_ff    <= '0;
         cmp_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bin_valid_ff    <= bin_valid_in;
         rd_valid_ff     <= bin_valid_ff[mem_raddr];
         bounds_ready_ff <= bounds_ready_in;
         low_bin_ff      <= low_bin_in;
         high_bin_ff     <= high_bin_in;
         cmp_vld_ff      <= cmp_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            min_count_ff <= csr_min_count;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

`ifndef NO_ASSERTIONS
   // a result only ever leaves the bound check or the divider
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff == ST_SETUP) || $past(state_ff == ST_DIVIDE)))
      else $error("result strobe without a mapping step");

   // mapping never works on stale bounds
   a_setup_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |-> bounds_ready_ff)
      else $error("mapping with bounds not scanned");

   // a finished scan with a bin found keeps the bounds in order
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (bounds_ready_ff && !low_bin_ff[BIN_BITS]) |-> (high_bin_ff >= low_bin_ff))
      else $error("high bound below low bound");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");
`endif

endmodule

FILE: tb/sv/testbench.sv
module testbench;
   import hcs_pkg::*;

   // mode 3 carries no operation, the block just drops the item
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   // longest quiet stretch: a full bin scan plus the divider plus sender gaps
   localparam int WATCHDOG_LIMIT = 5000;
   // count items finish with the bin write back after they are taken, leave a margin
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 20;
   localparam int PHASE_ITEMS    = 160;
   localparam int PRINT_LIMIT    = 40;

   // software copy of the histogram and the stretch bounds
   class stretch_scoreboard;
      logic [COUNT_BITS-1:0] bin_count [BINS];
      logic [BOUND_BITS-1:0] low_bin;
      logic [BOUND_BITS-1:0] high_bin;
      bit                    bounds_known;
      logic [MIN_BITS-1:0]   threshold;
      logic [PIXEL_BITS-1:0] expected_pixels [$];
      int                    mismatches;
      int                    scans;

      function new();
         foreach (bin_count[i]) bin_count[i] = '0;
         low_bin      = '0;
         high_bin     = '0;
         bounds_known = 1'b0;
         threshold    = '0;
         mismatches   = 0;
         scans        = 0;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("mismatch: %s", msg);
      endtask

      function void set_threshold(logic [MIN_BITS-1:0] value);
         threshold = value;
      endfunction

      // lowest and highest bin holding more than the threshold
      function void scan_histogram();
         bit found;
         found    = 1'b0;
         low_bin  = BOUND_BITS'(BINS);
         high_bin = '0;
         for (int i = 0; i < BINS; i++) begin
            if (bin_count[i] > threshold) begin
               if (!found) low_bin = BOUND_BITS'(i);
               high_bin = BOUND_BITS'(i);
               found    = 1'b1;
            end
         end
         bounds_known = 1'b1;
         scans++;
      endfunction

      function logic [PIXEL_BITS-1:0] stretch(logic [PIXEL_BITS-1:0] p);
         int pv;
         int lo;
         int hi;
         int r;
         if (!bounds_known) scan_histogram();
         pv = int'(p);
         lo = int'(low_bin);
         hi = int'(high_bin);
         if (pv < lo)       r = 0;
         else if (pv > hi)  r = 255;
         else if (hi <= lo) r = 255;
         else               r = (255 * (pv - lo)) / (hi - lo);
         return r[PIXEL_BITS-1:0];
      endfunction

      function void note_item(logic [MODE_BITS-1:0] mode, logic [PIXEL_BITS-1:0] p);
         case (mode)
            MODE_CLEAR: begin
               foreach (bin_count[i]) bin_count[i] = '0;
               bounds_known = 1'b0;
            end
            MODE_COUNT: begin
               if (bin_count[p] != COUNT_MAX) bin_count[p] = bin_count[p] + 1'b1;
               bounds_known = 1'b0;
            end
            MODE_MAP: expected_pixels.push_back(stretch(p));
            default: ;
         endcase
      endfunction

      task check_pixel(logic [PIXEL_BITS-1:0] got);
         logic [PIXEL_BITS-1:0] want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("out_pixel %0d with no map item waiting", got));
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want)
               report_mismatch($sformatf("out_pixel got %0d, want %0d", got, want));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [MODE_BITS-1:0]  req_mode;
   logic [PIXEL_BITS-1:0] req_pixel;
   logic                  rsp_valid;
   logic [PIXEL_BITS-1:0] rsp_out_pixel;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [MIN_BITS-1:0]   csr_min_count;

   stretch_scoreboard sb = new();

   int idle_pct       = 0;
   int items_accepted = 0;
   int pixels_checked = 0;
   int frames_sent    = 0;
   int idle_cycles    = 0;

   histogram_contrast_stretch u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_out_pixel (rsp_out_pixel),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_min_count (csr_min_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // all handshakes are observed here, at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            sb.check_pixel(rsp_out_pixel);
            pixels_checked++;
         end
         if (start && !busy) begin
            sb.note_item(req_mode, req_pixel);
            items_accepted++;
         end
         if (csr_valid && csr_ready) sb.set_threshold(csr_min_count);
      end
   end

   // watchdog: any handshake restarts the count of quiet cycles
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one item: optional gap cycles with start low, then hold until taken
   task automatic send_item(logic [MODE_BITS-1:0] mode, logic [PIXEL_BITS-1:0] p);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start     <= 1'b1;
      req_mode  <= mode;
      req_pixel <= p;
      do @(posedge clock); while (busy);
   endtask

   // sender holds off until every stretched pixel is back and counts have landed
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [MIN_BITS-1:0] value);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_min_count <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly whole frames: clear, a burst of counts in a window, then maps;
   // the rest is noise that breaks the frame pattern
   task automatic run_frames(int quota);
      int sent;
      int lo_w;
      int hi_w;
      int n_counts;
      int n_maps;
      int p;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 99) < 10) begin
            case ($urandom_range(0, 2))
               0: send_item(MODE_UNUSED, PIXEL_BITS'($urandom));
               1: begin
                  send_item(MODE_COUNT, PIXEL_BITS'($urandom));
                  sent++;
               end
               default: begin
                  send_item(MODE_MAP, PIXEL_BITS'($urandom));
                  sent++;
               end
            endcase
         end else begin
            // now and then keep the old histogram so counts pile up
            if ($urandom_range(0, 7) != 0) begin
               send_item(MODE_CLEAR, PIXEL_BITS'($urandom));
               sent++;
            end
            lo_w     = $urandom_range(0, 255);
            hi_w     = $urandom_range(lo_w, 255);
            n_counts = $urandom_range(1, 40);
            repeat (n_counts) begin
               send_item(MODE_COUNT, PIXEL_BITS'($urandom_range(lo_w, hi_w)));
               sent++;
            end
            n_maps = $urandom_range(1, 30);
            repeat (n_maps) begin
               // a quarter of the maps sit on the window edges
               if ($urandom_range(0, 3) == 0) begin
                  case ($urandom_range(0, 3))
                     0:       p = lo_w;
                     1:       p = hi_w;
                     2:       p = (lo_w > 0) ? lo_w - 1 : 0;
                     default: p = (hi_w < 255) ? hi_w + 1 : 255;
                  endcase
               end else begin
                  p = $urandom_range(0, 255);
               end
               send_item(MODE_MAP, PIXEL_BITS'(p));
               sent++;
            end
            frames_sent++;
            if ($urandom_range(0, 15) == 0) wait_drained();
         end
      end
   endtask

   initial begin
      int ph;
      logic [MIN_BITS-1:0] value;

      reset         = 1'b1;
      start         = 1'b0;
      req_mode      = MODE_CLEAR;
      req_pixel     = '0;
      csr_valid     = 1'b0;
      csr_min_count = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_threshold('0);

      // directed: empty histogram, every pixel stretches to 0
      send_item(MODE_MAP, 8'd0);
      send_item(MODE_MAP, PIXEL_MAX);
      // unused mode, both extremes of the pixel
      send_item(MODE_UNUSED, PIXEL_MAX);
      send_item(MODE_UNUSED, 8'd0);
      // single occupied bin: at it gives 255, below 0, above 255
      send_item(MODE_COUNT, 8'd7);
      send_item(MODE_COUNT, 8'd7);
      send_item(MODE_MAP, 8'd7);
      send_item(MODE_MAP, 8'd6);
      send_item(MODE_MAP, 8'd8);
      // full range, pixel 255 in its own bin
      send_item(MODE_COUNT, 8'd0);
      send_item(MODE_COUNT, PIXEL_MAX);
      send_item(MODE_MAP, 8'd0);
      send_item(MODE_MAP, 8'd1);
      send_item(MODE_MAP, 8'd128);
      send_item(MODE_MAP, PIXEL_MAX);
      // clear empties the histogram again
      send_item(MODE_CLEAR, 8'hA5);
      send_item(MODE_MAP, 8'd128);
      // only the top bin
      send_item(MODE_COUNT, PIXEL_MAX);
      send_item(MODE_MAP, PIXEL_MAX);
      send_item(MODE_MAP, 8'd254);
      // alternating bit patterns
      send_item(MODE_COUNT, 8'h55);
      send_item(MODE_COUNT, 8'hAA);
      send_item(MODE_MAP, 8'h55);
      send_item(MODE_MAP, 8'h80);
      send_item(MODE_MAP, 8'hAA);

      // random phases, each with its own threshold; sender idling changes every two phases
      for (ph = 0; ph < 6; ph++) begin
         idle_pct = (ph < 2) ? 21 : (ph < 4) ? 52 : 0;
         case (ph)
            0:       value = 24'd1;
            1:       value = {MIN_BITS{1'b1}};
            2:       value = 24'd0;
            3:       value = 24'd3;
            4:       value = MIN_BITS'($urandom_range(0, 6));
            default: value = 24'd2;
         endcase
         wait_drained();
         write_threshold(value);
         run_frames(PHASE_ITEMS);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.expected_pixels.size() != 0)
         sb.report_mismatch($sformatf("%0d stretched pixels never came",
                                      sb.expected_pixels.size()));

      $display("covered %0d items in %0d frames, %0d stretched pixels checked, %0d scans",
               items_accepted, frames_sent, pixels_checked, sb.scans);
      $display("thresholds 0 to max, sender idling 21, 52 and 0 percent, %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/hcs_pkg.sv
src/hcs_div.sv
src/histogram_contrast_stretch.sv
tb/sv/testbench.sv
